/* design/wildcard_byte_pattern_scan_top_defines.svh */
// assertion macros shared by the scan block
`ifndef WILDCARD_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

// property checked on every rising edge outside reset
`define WBPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never be seen outside reset
`define WBPS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* design/wbps_pkg.sv */
package wbps_pkg;

	localparam int DATA_W     = 64;
	localparam int REG_ADDR_W = 6;
	localparam int LEN_W      = 6;
	localparam int PAT_POS    = 32;
	localparam int PAT_WORDS  = 4;

	typedef enum logic [2:0] {
		REG_BASE_ADDRESS   = 3'd0,
		REG_PATTERN_LENGTH = 3'd1,
		REG_PATTERN_BYTES0 = 3'd2,
		REG_PATTERN_BYTES1 = 3'd3,
		REG_PATTERN_BYTES2 = 3'd4,
		REG_PATTERN_BYTES3 = 3'd5,
		REG_CARE_MASK      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [63:0]                     base_address;
		logic [LEN_W-1:0]                pattern_length;
		logic [PAT_WORDS-1:0][63:0]      pattern_words;
		logic [PAT_POS-1:0]              care_mask;
	} cfg_t;

endpackage

/* design/wbps_regs.sv */
module wbps_regs
	import wbps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE_ADDRESS:   cfg_q.base_address     <= pwdata;
				REG_PATTERN_LENGTH: cfg_q.pattern_length   <= pwdata[LEN_W-1:0];
				REG_PATTERN_BYTES0: cfg_q.pattern_words[0] <= pwdata;
				REG_PATTERN_BYTES1: cfg_q.pattern_words[1] <= pwdata;
				REG_PATTERN_BYTES2: cfg_q.pattern_words[2] <= pwdata;
				REG_PATTERN_BYTES3: cfg_q.pattern_words[3] <= pwdata;
				REG_CARE_MASK:      cfg_q.care_mask        <= pwdata[PAT_POS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASE_ADDRESS:   prdata = cfg_q.base_address;
			REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.pattern_length};
			REG_PATTERN_BYTES0: prdata = cfg_q.pattern_words[0];
			REG_PATTERN_BYTES1: prdata = cfg_q.pattern_words[1];
			REG_PATTERN_BYTES2: prdata = cfg_q.pattern_words[2];
			REG_PATTERN_BYTES3: prdata = cfg_q.pattern_words[3];
			REG_CARE_MASK:      prdata = {{(DATA_W-PAT_POS){1'b0}}, cfg_q.care_mask};
			default:            prdata = '0;
		endcase
	end

endmodule

/* design/wbps_match.sv */
module wbps_match
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int COUNT_BITS  = 32
) (
	input  cfg_t                  cfg,
	input  logic [7:0]            window [MAX_PATTERN],
	input  logic [COUNT_BITS-1:0] count,
	output logic                  hit,
	output logic [63:0]           match_address
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic [LEN_W-1:0]      len;
	logic [LEN_W-1:0]      pos      [MAX_PATTERN];
	logic [7:0]            apat     [MAX_PATTERN];
	logic                  acare    [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] ok;
	logic [COUNT_BITS-1:0] offset;

	assign len = (cfg.pattern_length > MAX_LEN) ? MAX_LEN : cfg.pattern_length;

	// window slot j (newest first) lines up with pattern position len-1-j
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pos[j]   = len - LEN_W'(j) - LEN_W'(1);
			apat[j]  = '0;
			acare[j] = 1'b0;
			for (int k = 0; k < PAT_POS; k++) begin
				if (pos[j] == LEN_W'(k)) begin
					apat[j]  = cfg.pattern_words[k >> 3][(k & 7) * 8 +: 8];
					acare[j] = cfg.care_mask[k];
				end
			end
			ok[j] = (LEN_W'(j) >= len) || !acare[j] || (window[j] == apat[j]);
		end
	end

	assign hit           = (len != '0) && (count >= COUNT_BITS'(len)) && (&ok);
	assign offset        = count - COUNT_BITS'(len);
	assign match_address = cfg.base_address + 64'(offset);

endmodule

/* design/wildcard_byte_pattern_scan_top.sv */
// Wildcard byte pattern scanner. Bytes of a memory region enter in address order, one
// transfer per cycle unless stalled; a result (found with its match address, and/or
// scan_done on the byte marked final) is registered after stage one. Matches
// that overlap are all reported. Throughput is one byte per clock, set by the single
// compare stage between the window register and the result register; the input stalls
// only while a result is blocked in the output register. Configuration goes through the
// APB port at byte address 8*index and should change only while no byte is in flight.
`include "wildcard_byte_pattern_scan_top_defines.svh"

module wildcard_byte_pattern_scan_top
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  final_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           match_address,
	output logic                  found,
	output logic                  scan_done,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	cfg_t                  cfg;
	logic [7:0]            window_s1 [MAX_PATTERN];
	logic [COUNT_BITS-1:0] count_s1;
	logic                  last_s1;
	logic                  valid_s1;
	logic                  hit;
	logic [63:0]           addr;
	logic                  produces;
	logic                  out_load;
	logic                  in_acc;
	logic [COUNT_BITS-1:0] count_base;
	logic                  out_valid_s2;
	logic                  found_s2;
	logic                  done_s2;
	logic [63:0]           addr_s2;

	wbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wbps_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.COUNT_BITS  (COUNT_BITS)
	) u_match (
		.cfg           (cfg),
		.window        (window_s1),
		.count         (count_s1),
		.hit           (hit),
		.match_address (addr)
	);

	assign produces = valid_s1 && (hit || last_s1);
	assign out_load = !out_valid_s2 || !out_stall;
	assign in_stall = produces && !out_load;
	assign in_acc   = in_valid && !in_stall;

	// window and count restart after the final byte of a region
	assign count_base = last_s1 ? '0 : count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			count_s1 <= '0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_s1[j] <= '0;
			end
		end else if (in_acc) begin
			valid_s1     <= 1'b1;
			last_s1      <= final_byte;
			count_s1     <= (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
			window_s1[0] <= data_byte;
			for (int j = 1; j < MAX_PATTERN; j++) begin
				window_s1[j] <= last_s1 ? 8'h00 : window_s1[j-1];
			end
		end else if (!in_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_load) begin
			out_valid_s2 <= produces;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && produces) begin
			found_s2 <= hit;
			done_s2  <= last_s1;
			addr_s2  <= hit ? addr : 64'd0;
		end
	end

	assign out_valid     = out_valid_s2;
	assign found         = found_s2;
	assign scan_done     = done_s2;
	assign match_address = addr_s2;

	`WBPS_ASSERT(a_result_has_reason, out_valid_s2 |-> (found_s2 || done_s2),
		"result without match or end of scan")
	`WBPS_ASSERT(a_miss_address_zero, (out_valid_s2 && !found_s2) |-> (addr_s2 == 64'd0),
		"nonzero address on a result without match")
	`WBPS_ASSERT(a_window_held, in_stall |=> ($stable(count_s1) && $stable(last_s1)),
		"stage one changed while blocked")
	`WBPS_ASSERT(a_restart_count, (in_acc && last_s1) |=> (count_s1 == COUNT_BITS'(1)),
		"byte count did not restart after final byte")
	`WBPS_ASSERT_NEVER(a_stall_when_empty, in_stall && !valid_s1,
		"input stalled with stage one empty")

endmodule
